/* rtl/core/brn_pkg.sv */
// Shared types, constants and the microcode ROM of the Roman numeral converter.
package brn_pkg;

    localparam int VALUE_W  = 12;
    localparam int LETTER_W = 7;
    localparam int WEIGHT_W = 10;
    localparam int STEP_W   = 4;

    localparam logic [VALUE_W-1:0] THOUSANDS_FOUR = 12'd4000;

    localparam logic [LETTER_W-1:0] CHAR_I = 7'h49;
    localparam logic [LETTER_W-1:0] CHAR_V = 7'h56;
    localparam logic [LETTER_W-1:0] CHAR_X = 7'h58;
    localparam logic [LETTER_W-1:0] CHAR_L = 7'h4C;
    localparam logic [LETTER_W-1:0] CHAR_C = 7'h43;
    localparam logic [LETTER_W-1:0] CHAR_D = 7'h44;
    localparam logic [LETTER_W-1:0] CHAR_M = 7'h4D;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [LETTER_W-1:0] ltr_a;
        logic [LETTER_W-1:0] ltr_b;
        logic                pair;
    } ctrl_word_t;

    typedef struct packed {
        logic load;
        logic sub_en;
    } dp_ctrl_t;

    typedef struct packed {
        logic rem_zero;
        logic fits;
        logic exact;
    } dp_status_t;

    typedef struct packed {
        logic                valid;
        logic [LETTER_W-1:0] letter;
        logic                last;
    } emit_t;

    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        unique case (step)
            4'd0:    w = '{10'd1000, CHAR_M, CHAR_M, 1'b0};
            4'd1:    w = '{10'd900,  CHAR_C, CHAR_M, 1'b1};
            4'd2:    w = '{10'd500,  CHAR_D, CHAR_D, 1'b0};
            4'd3:    w = '{10'd400,  CHAR_C, CHAR_D, 1'b1};
            4'd4:    w = '{10'd100,  CHAR_C, CHAR_C, 1'b0};
            4'd5:    w = '{10'd90,   CHAR_X, CHAR_C, 1'b1};
            4'd6:    w = '{10'd50,   CHAR_L, CHAR_L, 1'b0};
            4'd7:    w = '{10'd40,   CHAR_X, CHAR_L, 1'b1};
            4'd8:    w = '{10'd10,   CHAR_X, CHAR_X, 1'b0};
            4'd9:    w = '{10'd9,    CHAR_I, CHAR_X, 1'b1};
            4'd10:   w = '{10'd5,    CHAR_V, CHAR_V, 1'b0};
            4'd11:   w = '{10'd4,    CHAR_I, CHAR_V, 1'b1};
            default: w = '{10'd1,    CHAR_I, CHAR_I, 1'b0};
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/brn_datapath.sv */
// Remainder register with compare and subtract against the current weight.
module brn_datapath
    import brn_pkg::*;
(
    input  logic                aclk,
    input  dp_ctrl_t            ctrl,
    input  logic [VALUE_W-1:0]  load_value,
    input  logic [WEIGHT_W-1:0] weight,
    output dp_status_t          status
);

    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] rem_next;
    logic [VALUE_W-1:0] weight_ext;

    assign weight_ext = {{(VALUE_W-WEIGHT_W){1'b0}}, weight};

    always_comb begin
        rem_next = rem_reg;
        if (ctrl.load) begin
            // thousands digit four contributes no letters
            rem_next = (load_value >= THOUSANDS_FOUR) ? load_value - THOUSANDS_FOUR
                                                      : load_value;
        end else if (ctrl.sub_en) begin
            rem_next = rem_reg - weight_ext;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
    end

    assign status.rem_zero = (rem_reg == '0);
    assign status.fits     = (rem_reg >= weight_ext);
    assign status.exact    = (rem_reg == weight_ext);

endmodule

/* rtl/core/brn_sequencer.sv */
// Microcode sequencer: step counter, ROM fetch and conditional step advance.
module brn_sequencer
    import brn_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                emit_ok,
    input  dp_status_t          status,
    output logic                idle,
    output dp_ctrl_t            ctrl,
    output logic [WEIGHT_W-1:0] weight,
    output emit_t               emit
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SECOND
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ctrl_word_t        cw;

    assign cw     = ucode_rom(step_reg);
    assign weight = cw.weight;
    assign idle   = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        ctrl.load   = 1'b0;
        ctrl.sub_en = 1'b0;
        emit.valid  = 1'b0;
        emit.letter = cw.ltr_a;
        emit.last   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    ctrl.load  = 1'b1;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                priority if (status.rem_zero) begin
                    state_next = ST_IDLE;
                end else if (!status.fits) begin
                    step_next = step_reg + 1'b1;
                end else if (emit_ok) begin
                    emit.valid = 1'b1;
                    if (cw.pair) begin
                        state_next = ST_SECOND;
                    end else begin
                        ctrl.sub_en = 1'b1;
                        emit.last   = status.exact;
                    end
                end
            end
            ST_SECOND: begin
                emit.letter = cw.ltr_b;
                if (emit_ok) begin
                    emit.valid  = 1'b1;
                    emit.last   = status.exact;
                    ctrl.sub_en = 1'b1;
                    step_next   = step_reg + 1'b1;
                    state_next  = ST_RUN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* rtl/core/binary_to_roman_numeral_core.sv */
// First letter: the value is loaded, then each ROM step whose weight does not fit is skipped,
// and the fitting step's letter is registered in the output register; a zero check ends a value.
// Throughput: one value at a time; a new value is taken only once the sequencer is idle again.
// The step counter, its single compare-subtract on the remainder and output stalls set the pace.
// Reset: synchronous, active low; sequencer returns to idle and the output register empties.
// Top level: value input channel, letter output register and converter instances.
module binary_to_roman_numeral_core
    import brn_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [VALUE_W-1:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [LETTER_W-1:0] m_letter,
    output logic                m_last_letter
);

    dp_ctrl_t            ctrl;
    dp_status_t          status;
    emit_t               emit;
    logic [WEIGHT_W-1:0] weight;
    logic                idle;
    logic                emit_ok;

    logic                m_valid_reg;
    logic [LETTER_W-1:0] m_letter_reg;
    logic                m_last_reg;

    assign emit_ok = !m_valid_reg || m_ready;
    assign s_ready = idle;

    brn_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_valid),
        .emit_ok (emit_ok),
        .status  (status),
        .idle    (idle),
        .ctrl    (ctrl),
        .weight  (weight),
        .emit    (emit)
    );

    brn_datapath u_dp (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .load_value (s_value),
        .weight     (weight),
        .status     (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            m_letter_reg <= emit.letter;
            m_last_reg   <= emit.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_letter      = m_letter_reg;
    assign m_last_letter = m_last_reg;

endmodule

/* rtl/core/brn_checker.sv */
// Port-level assertions for the Roman numeral converter, bound to the top level.
module brn_checker
    import brn_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [LETTER_W-1:0] m_letter,
    input logic                m_last_letter
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_letter) && $stable(m_last_letter))
        else $error("output transaction changed while stalled");

    a_letter_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_letter == CHAR_I || m_letter == CHAR_V || m_letter == CHAR_X ||
                     m_letter == CHAR_L || m_letter == CHAR_C || m_letter == CHAR_D ||
                     m_letter == CHAR_M))
        else $error("illegal numeral letter");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before conversion started");

    a_busy_mid_numeral: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_letter |-> !s_ready)
        else $error("input ready while numeral incomplete");

endmodule

bind binary_to_roman_numeral_core brn_checker u_brn_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_letter      (m_letter),
    .m_last_letter (m_last_letter)
);

/* verif/binary_to_roman_numeral_core_tb.sv */
// Self-checking testbench: Roman numeral letter stream against typed numerals and a numeral predictor.
module binary_to_roman_numeral_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import brn_pkg::*;

    localparam int  DIR_N      = 25;
    localparam int  RAND_N     = 325;
    localparam int  HOLD_LEN   = 250;
    localparam int  TAIL_LEN   = 64;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  IDLE_PCT   = 37;
    localparam int  PRINT_CAP  = 100;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
    } letter_exp_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [VALUE_W-1:0]  s_value = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [LETTER_W-1:0] m_letter;
    logic                m_last_letter;

    letter_exp_t expected_letters[$];
    string       numeral_source[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          hold_left      = 0;
    int          stall_requests = 0;
    int          stall_served   = 0;
    logic        calm           = 1'b0;

    // "*" rows are checked against the predictor
    logic [VALUE_W-1:0] dir_value [DIR_N] = '{
        12'd0,    12'd1,    12'd3,    12'd4,    12'd5,
        12'd9,    12'd3999, 12'd3888, 12'd4000, 12'd4001,
        12'd4095, 12'd2048, 12'd1024, 12'd40,   12'd90,
        12'd400,  12'd900,  12'd444,  12'd1994, 12'd14,
        12'd49,   12'd1000, 12'd10,   12'd2730, 12'd1365
    };
    string dir_numeral [DIR_N] = '{
        "",     "I",         "III",             "IV",  "V",
        "IX",   "MMMCMXCIX", "MMMDCCCLXXXVIII", "",    "I",
        "XCV",  "*",         "*",               "XL",  "XC",
        "CD",   "CM",        "*",               "*",   "*",
        "*",    "M",         "*",               "*",   "*"
    };

    binary_to_roman_numeral_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_letter      (m_letter),
        .m_last_letter (m_last_letter)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    function automatic void push_letter(input logic [LETTER_W-1:0] ch);
        expected_letters.push_back('{letter: ch, last: 1'b0});
    endfunction

    function automatic void push_digit_letters(input int d, input logic [LETTER_W-1:0] one,
                                               input logic [LETTER_W-1:0] five,
                                               input logic [LETTER_W-1:0] ten);
        int k;
        if (d == 9) begin
            push_letter(one);
            push_letter(ten);
        end else if (d == 4) begin
            push_letter(one);
            push_letter(five);
        end else if (d >= 5) begin
            push_letter(five);
            for (k = 5; k < d; k++) push_letter(one);
        end else begin
            for (k = 0; k < d; k++) push_letter(one);
        end
    endfunction

    function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
        int n;
        int k;
        int start;
        n = int'(v);
        start = expected_letters.size();
        if (n / 1000 <= 3) begin
            for (k = 0; k < n / 1000; k++) push_letter(CHAR_M);
        end
        push_digit_letters((n % 1000) / 100, CHAR_C, CHAR_D, CHAR_M);
        push_digit_letters((n % 100) / 10, CHAR_X, CHAR_L, CHAR_C);
        push_digit_letters(n % 10, CHAR_I, CHAR_V, CHAR_X);
        if (expected_letters.size() > start) begin
            expected_letters[expected_letters.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void push_typed_numeral(input string s);
        int  k;
        byte ch;
        for (k = 0; k < s.len(); k++) begin
            ch = s[k];
            expected_letters.push_back('{letter: ch[LETTER_W-1:0], last: (k == s.len() - 1)});
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pick_digit_heavy();
        int digs[3];
        int k;
        for (k = 0; k < 3; k++) begin
            case ($urandom_range(0, 3))
                0:       digs[k] = 4;
                1:       digs[k] = 9;
                default: digs[k] = $urandom_range(0, 9);
            endcase
        end
        return VALUE_W'($urandom_range(0, 3) * 1000 + digs[0] * 100 + digs[1] * 10 + digs[2]);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)      return VALUE_W'($urandom_range(1, 3999));
        else if (sel < 75) return pick_digit_heavy();
        else if (sel < 85) return VALUE_W'($urandom_range(4000, 4095));
        else if (sel < 90) return '0;
        else               return VALUE_W'($urandom_range(0, 4095));
    endfunction

    function automatic bit sender_idles();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    task automatic offer_value(input logic [VALUE_W-1:0] v);
        while (sender_idles()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_served != stall_requests) begin
            stall_served <= stall_requests;
            hold_left    <= HOLD_LEN;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        string       src;
        letter_exp_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (numeral_source.size() == 0) begin
                    report_mismatch($sformatf("input transaction %0d not offered", s_value));
                end else begin
                    src = numeral_source.pop_front();
                    if (src == "*") predict_numeral(s_value);
                    else            push_typed_numeral(src);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_letters.size() == 0) begin
                    report_mismatch($sformatf("unexpected letter 0x%02h last %0b",
                                              m_letter, m_last_letter));
                end else begin
                    want = expected_letters.pop_front();
                    if (m_letter !== want.letter) begin
                        report_mismatch($sformatf("letter 0x%02h, expected 0x%02h",
                                                  m_letter, want.letter));
                    end
                    if (m_last_letter !== want.last) begin
                        report_mismatch($sformatf("last_letter %0b, expected %0b (letter 0x%02h)",
                                                  m_last_letter, want.last, want.letter));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int i;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < DIR_N; i++) begin
            numeral_source.push_back(dir_numeral[i]);
            offer_value(dir_value[i]);
        end

        for (i = 0; i < RAND_N; i++) begin
            if (i == 40) stall_requests <= stall_requests + 1;
            calm <= (i >= 150 && i < 220);
            numeral_source.push_back("*");
            offer_value(pick_value());
        end
        s_valid <= 1'b0;
        calm    <= 1'b0;

        while (expected_letters.size() != 0) @(posedge aclk);
        repeat (TAIL_LEN) @(posedge aclk);

        if (expected_letters.size() != 0) begin
            report_mismatch($sformatf("%0d letters never arrived", expected_letters.size()));
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
